// ----- rtl/ccrop_pkg.sv -----
// ccrop_pkg: shared types, register codes and channel scaling for the centre crop block
// no dependencies; imported by every module of the block

package ccrop_pkg;

    // configuration port geometry
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CROP_SIDE    = 2'd2;

    // register reset values
    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd320;
    localparam logic [11:0] FRAME_HEIGHT_RST = 12'd240;
    localparam logic [8:0]  CROP_SIDE_RST    = 9'd64;

    // stream marker bytes
    localparam logic [7:0] HDR_BYTE0 = 8'hFF;
    localparam logic [7:0] HDR_BYTE1 = 8'hAA;
    localparam logic [7:0] FTR_BYTE0 = 8'hBB;
    localparam logic [7:0] FTR_BYTE1 = 8'hFF;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // configuration register contents
    typedef struct packed {
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic [8:0]  crop_side;
    } cfg_t;

    // one kept pixel with its framing marks
    typedef struct packed {
        logic [4:0] red;
        logic [5:0] green;
        logic [4:0] blue;
        logic       head;
        logic       foot;
    } pix_entry_t;

    // which byte of a kept pixel is on the result port
    typedef enum logic [2:0] {
        SEL_HDR0,
        SEL_HDR1,
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE,
        SEL_FTR0,
        SEL_FTR1
    } byte_sel_t;

    // c*255/31 truncated: 8c plus floor(7c/31)
    function automatic logic [7:0] scale5(input logic [4:0] c);
        logic [7:0] p7;
        logic [2:0] q;
        p7 = 8'(c) * 8'd7;
        q  = 3'd0;
        for (int k = 1; k <= 7; k++) begin
            if (p7 >= 8'(31 * k)) begin
                q = q + 3'd1;
            end
        end
        return {c, 3'b000} + 8'(q);
    endfunction

    // c*255/63 truncated: 4c plus floor(c/21)
    function automatic logic [7:0] scale6(input logic [5:0] c);
        logic [1:0] q;
        q = 2'd0;
        if (c >= 6'd21) q = q + 2'd1;
        if (c >= 6'd42) q = q + 2'd1;
        if (c >= 6'd63) q = q + 2'd1;
        return {c, 2'b00} + 8'(q);
    endfunction

endpackage

// ----- rtl/center_crop_rgb565_to_rgb888.sv -----
// center_crop_rgb565_to_rgb888: top level of the centre crop and rgb565 to rgb888 converter
// depends on ccrop_pkg, ccrop_cfg, ccrop_front, ccrop_queue, ccrop_back

// Pixels arrive in raster order, one per item; the front tracks column and row, keeps those
// inside the centred square window and places them in a two-entry queue, so an item is taken
// every cycle while the queue has room. Pixels outside the window give no result. Each kept
// pixel leaves as bytes on the byte-wide result port, one per cycle while pop is held: three
// for r, g, b, five with the FF AA header or BB FF footer, seven with both. Configuration
// takes effect on the next item; write it only while the block is idle.

module center_crop_rgb565_to_rgb888
    import ccrop_pkg::*;
#(
    parameter int MAX_DIM_BITS = 11
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // pixel input
    input  logic               push,
    output logic               full,
    input  logic [15:0]        pixel,
    input  logic               frame_start,
    // byte output
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         out_byte,
    output logic               last
);

    cfg_t       cfg;
    logic       accept;
    logic       keep;
    pix_entry_t front_entry;
    pix_entry_t head;
    logic       head_valid;
    logic       deq;

    assign accept = push && !full;

    // register file
    ccrop_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // position tracking and classification
    ccrop_front #(
        .MAX_DIM_BITS (MAX_DIM_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .pixel       (pixel),
        .frame_start (frame_start),
        .keep        (keep),
        .entry       (front_entry)
    );

    // kept pixel queue
    ccrop_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .enq        (accept && keep),
        .enq_entry  (front_entry),
        .deq        (deq),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    // byte sequencer
    ccrop_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_byte   (out_byte),
        .last       (last),
        .empty      (empty),
        .deq        (deq)
    );

endmodule

// ----- rtl/ccrop_cfg.sv -----
// ccrop_cfg: apb-style register file holding frame size and crop side
// depends on ccrop_pkg

module ccrop_cfg
    import ccrop_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [11:0] frame_width_reg;
    logic [11:0] frame_height_reg;
    logic [8:0]  crop_side_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            crop_side_reg    <= CROP_SIDE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[11:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[11:0];
                REG_CROP_SIDE:    crop_side_reg    <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_reg);
            REG_CROP_SIDE:    prdata = PDATA_W'(crop_side_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.frame_width  = frame_width_reg;
    assign cfg.frame_height = frame_height_reg;
    assign cfg.crop_side    = crop_side_reg;

endmodule

// ----- rtl/ccrop_front.sv -----
// ccrop_front: raster position tracking and window classification of each pixel
// depends on ccrop_pkg

module ccrop_front
    import ccrop_pkg::*;
#(
    parameter int MAX_DIM_BITS = 11
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic [15:0] pixel,
    input  logic       frame_start,
    output logic       keep,
    output pix_entry_t entry
);

    // dimension width holds 2^MAX_DIM_BITS; calc width also holds the raw register
    localparam int DW = MAX_DIM_BITS + 1;
    localparam int CW = (DW > 12) ? DW : 12;
    localparam logic [CW-1:0] LIMIT = CW'(1) << MAX_DIM_BITS;
    localparam logic [CW-1:0] ONE   = CW'(1);

    logic [MAX_DIM_BITS-1:0] col_reg, col_next;
    logic [MAX_DIM_BITS-1:0] row_reg, row_next;

    logic [CW-1:0] w_raw, h_raw, side_raw;
    logic [CW-1:0] w, h, side_a, side_b, side;
    logic [CW-1:0] sx, sy, ex, ey;
    logic [CW-1:0] col, row, col_inc, row_inc;
    logic          in_x, in_y;

    // clamp dimensions and window side
    always_comb
    begin
        w_raw    = CW'(cfg.frame_width);
        h_raw    = CW'(cfg.frame_height);
        side_raw = CW'(cfg.crop_side);
        w = (w_raw == '0) ? ONE : ((w_raw > LIMIT) ? LIMIT : w_raw);
        h = (h_raw == '0) ? ONE : ((h_raw > LIMIT) ? LIMIT : h_raw);
        side_a = (side_raw == '0) ? ONE : side_raw;
        side_b = (side_a > w) ? w : side_a;
        side   = (side_b > h) ? h : side_b;
        sx = (w - side) >> 1;
        sy = (h - side) >> 1;
        ex = sx + side;
        ey = sy + side;
    end

    // position of this pixel and window test
    always_comb
    begin
        col  = frame_start ? '0 : CW'(col_reg);
        row  = frame_start ? '0 : CW'(row_reg);
        in_x = (col >= sx) && (col < ex);
        in_y = (row >= sy) && (row < ey);
        keep = in_x && in_y;
        entry.red   = pixel[15:11];
        entry.green = pixel[10:5];
        entry.blue  = pixel[4:0];
        entry.head  = (col == sx) && (row == sy);
        entry.foot  = (col == ex - ONE) && (row == ey - ONE);
    end

    // advance raster position, wrap at frame edges
    always_comb
    begin
        col_inc = col + ONE;
        row_inc = row + ONE;
        if (col_inc >= w)
        begin
            col_next = '0;
            row_next = (row_inc >= h) ? '0 : row_inc[MAX_DIM_BITS-1:0];
        end
        else
        begin
            col_next = col_inc[MAX_DIM_BITS-1:0];
            row_next = row[MAX_DIM_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ----- rtl/ccrop_queue.sv -----
// ccrop_queue: short queue of kept pixels between front and back
// depends on ccrop_pkg

module ccrop_queue
    import ccrop_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       enq,
    input  pix_entry_t enq_entry,
    input  logic       deq,
    output pix_entry_t head,
    output logic       head_valid,
    output logic       full
);

    pix_entry_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head       = mem[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            mem[wr_ptr_reg] <= enq_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (enq)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (deq)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (enq && !deq)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (deq && !enq)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/ccrop_back.sv -----
// ccrop_back: byte sequencer turning each queued pixel into header, rgb888 and footer bytes
// depends on ccrop_pkg

module ccrop_back
    import ccrop_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pix_entry_t head,
    input  logic       head_valid,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       empty,
    output logic       deq
);

    byte_sel_t sel_reg, sel_next;
    logic      started_reg, started_next;
    byte_sel_t first_sel, final_sel, cur_sel;
    logic      take;

    assign empty = !head_valid;
    assign take  = pop && head_valid;

    // byte range of the current item
    always_comb
    begin
        first_sel = head.head ? SEL_HDR0 : SEL_RED;
        final_sel = head.foot ? SEL_FTR1 : SEL_BLUE;
        cur_sel   = started_reg ? sel_reg : first_sel;
        deq       = take && (cur_sel == final_sel);
    end

    // next byte selection
    always_comb
    begin
        sel_next     = sel_reg;
        started_next = started_reg;
        if (take)
        begin
            if (cur_sel == final_sel)
            begin
                started_next = 1'b0;
            end
            else
            begin
                started_next = 1'b1;
                unique case (cur_sel)
                    SEL_HDR0:  sel_next = SEL_HDR1;
                    SEL_HDR1:  sel_next = SEL_RED;
                    SEL_RED:   sel_next = SEL_GREEN;
                    SEL_GREEN: sel_next = SEL_BLUE;
                    SEL_BLUE:  sel_next = SEL_FTR0;
                    SEL_FTR0:  sel_next = SEL_FTR1;
                    default:   sel_next = SEL_FTR1;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg     <= SEL_HDR0;
            started_reg <= 1'b0;
        end
        else
        begin
            sel_reg     <= sel_next;
            started_reg <= started_next;
        end
    end

    // result byte mux
    always_comb
    begin
        last = 1'b0;
        unique case (cur_sel)
            SEL_HDR0:  out_byte = HDR_BYTE0;
            SEL_HDR1:  out_byte = HDR_BYTE1;
            SEL_RED:   out_byte = scale5(head.red);
            SEL_GREEN: out_byte = scale6(head.green);
            SEL_BLUE:  out_byte = scale5(head.blue);
            SEL_FTR0:  out_byte = FTR_BYTE0;
            SEL_FTR1:
            begin
                out_byte = FTR_BYTE1;
                last     = 1'b1;
            end
            default:   out_byte = '0;
        endcase
    end

endmodule

// ----- rtl/ccrop_checker.sv -----
// ccrop_checker: port-level checks on the centre crop block, bound to the top level
// depends on ccrop_pkg and center_crop_rgb565_to_rgb888

module ccrop_checker
    import ccrop_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       full,
    input logic       pop,
    input logic       empty,
    input logic [7:0] out_byte,
    input logic       last
);

    // queue and sequencer are empty in the cycle after reset is seen
    assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("block not empty while in reset");

    // the frame mark only rides on the final footer byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (out_byte == FTR_BYTE1))
        else $error("last set on a byte other than the closing footer");

    // footer byte is always followed by the closing byte of the same item
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && out_byte == FTR_BYTE0) |=> (!empty && last))
        else $error("footer not completed by the closing byte");

    // a waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last)))
        else $error("waiting result changed before it was taken");

endmodule

bind center_crop_rgb565_to_rgb888 ccrop_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .last     (last)
);
